[hw/rtl/bcc_pkg.sv]
// Button click classifier package: event codes, register indexes, reset values
// and the config struct passed between the config block, the core and the top level.
// No dependencies.
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_DCLICK   = 2'd1,
        CFG_LONG     = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] DCLICK_RST   = 16'd300;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] window_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

endpackage

[hw/rtl/bcc_cfg.sv]
// Button click classifier configuration registers.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_cfg
    import bcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [CFG_W-1:0]     i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_DEBOUNCE: n_cfg.settle_ms     = i_wr_data;
                CFG_DCLICK:   n_cfg.window_ms     = i_wr_data;
                CFG_LONG:     n_cfg.long_press_ms = i_wr_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ms     <= DEBOUNCE_RST;
            r_cfg.window_ms     <= DCLICK_RST;
            r_cfg.long_press_ms <= LONG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/bcc_core.sv]
// Button click classifier core: debounce and click state plus the one-pass
// classification of a sample. Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_core
    import bcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_raw_level,
    input  logic [TIME_W-1:0] i_now_ms,
    input  t_cfg              i_cfg,
    output t_event            o_event
);

    logic              r_prev_raw,  n_prev_raw;
    logic              r_stable,    n_stable;
    logic [TIME_W-1:0] r_change_t,  n_change_t;
    logic [TIME_W-1:0] r_press_t,   n_press_t;
    logic              r_long_rep,  n_long_rep;
    logic [TIME_W-1:0] r_release_t, n_release_t;
    logic              r_awaiting,  n_awaiting;

    logic [TIME_W-1:0] change_el;
    logic [TIME_W-1:0] release_el_old;
    logic [TIME_W-1:0] release_el;
    logic [TIME_W-1:0] press_el;
    logic              press_set;
    logic              release_set;
    logic              is_double;
    t_event            ev;

    assign change_el      = i_now_ms - r_change_t;
    assign release_el_old = i_now_ms - r_release_t;

    always_comb begin
        n_prev_raw  = r_prev_raw;
        n_stable    = r_stable;
        n_change_t  = r_change_t;
        n_press_t   = r_press_t;
        n_long_rep  = r_long_rep;
        n_release_t = r_release_t;
        n_awaiting  = r_awaiting;
        press_set   = 1'b0;
        release_set = 1'b0;
        is_double   = 1'b0;
        press_el    = '0;
        release_el  = '0;
        ev          = EV_NONE;

        if (i_raw_level != r_prev_raw) begin
            // raw edge restarts the debounce timer and nothing else
            n_prev_raw = i_raw_level;
            n_change_t = i_now_ms;
        end else if (change_el >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.settle_ms}) begin
            if (i_raw_level != r_stable) begin
                n_stable = i_raw_level;
                if (!i_raw_level) begin
                    if (r_awaiting && release_el_old <
                            {{(TIME_W-CFG_W){1'b0}}, i_cfg.window_ms}) begin
                        n_awaiting = 1'b0;
                        n_long_rep = 1'b1;
                        is_double  = 1'b1;
                    end else begin
                        press_set  = 1'b1;
                        n_press_t  = i_now_ms;
                        n_long_rep = 1'b0;
                        n_awaiting = 1'b0;
                    end
                end else if (!r_long_rep) begin
                    release_set = 1'b1;
                    n_release_t = i_now_ms;
                    n_awaiting  = 1'b1;
                end
            end

            // freshly stamped times read as zero elapsed
            press_el   = press_set   ? '0 : (i_now_ms - r_press_t);
            release_el = release_set ? '0 : release_el_old;

            if (is_double) begin
                ev = EV_DOUBLE;
            end else if (!n_stable && !n_long_rep &&
                         press_el >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms}) begin
                n_long_rep = 1'b1;
                n_awaiting = 1'b0;
                ev         = EV_LONG;
            end else if (n_awaiting &&
                         release_el >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.window_ms}) begin
                n_awaiting = 1'b0;
                ev         = EV_SINGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw  <= 1'b1;
            r_stable    <= 1'b1;
            r_change_t  <= '0;
            r_press_t   <= '0;
            r_long_rep  <= 1'b0;
            r_release_t <= '0;
            r_awaiting  <= 1'b0;
        end else if (i_step) begin
            r_prev_raw  <= n_prev_raw;
            r_stable    <= n_stable;
            r_change_t  <= n_change_t;
            r_press_t   <= n_press_t;
            r_long_rep  <= n_long_rep;
            r_release_t <= n_release_t;
            r_awaiting  <= n_awaiting;
        end
    end

    assign o_event = ev;

    // a pending window only exists while the button is released
    a_await_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> r_stable)
        else $error("awaiting second press while stable level is pressed");

endmodule

[hw/rtl/button_click_classifier.sv]
// Button click classifier top level: input register, core, result register.
// Depends on bcc_pkg, bcc_cfg, bcc_core.
`timescale 1ns / 1ps

// One sample (pin level plus millisecond timestamp) gives exactly one event
// code. A sample is registered on transfer, classified against the current
// debounce and click state as it leaves the input register, and the code lands
// in the result register. One sample per cycle is sustained while the result
// side does not stall; the core updates its state in one pass. A stalled result
// holds the input register; a further sample is taken once it moves on.
// Configuration writes are accepted every cycle and should only be made while
// no samples are in flight.
module button_click_classifier
    import bcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_raw_level,
    input  logic [TIME_W-1:0]    i_now_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_event_code,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg              cfg;
    t_event            ev;

    logic              r_in_valid;
    logic              r_raw;
    logic [TIME_W-1:0] r_now;
    logic              r_out_valid;
    t_event            r_event;
    logic              advance;

    assign o_cfg_ready = 1'b1;

    bcc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // sample moves to the result register when that slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bcc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_raw_level (r_raw),
        .i_now_ms    (r_now),
        .i_cfg       (cfg),
        .o_event     (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_raw <= i_raw_level;
            r_now <= i_now_ms;
        end
        if (advance) begin
            r_event <= ev;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_now) && $stable(r_raw))
        else $error("stalled sample lost or changed");

    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("classified sample produced no result");

endmodule

[verif/button_click_classifier_test.sv]
// Testbench for button_click_classifier: sends pin samples and register writes,
// predicts every event code and checks the results in order of transfer.
// Depends on bcc_pkg and the button_click_classifier RTL.
`timescale 1ns / 1ps

module button_click_classifier_test;
    import bcc_pkg::*;

    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int unsigned MAX_GAP     = 17;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned REPORT_MAX  = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic                 i_raw_level = 1'b1;
    logic [TIME_W-1:0]    i_now_ms    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_event_code;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    button_click_classifier DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_raw_level  (i_raw_level),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_code (o_event_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted block state and settings
    logic [CFG_W-1:0]  db_ms, dc_ms, lp_ms;
    logic              pin_last, level_settled, long_done, window_open;
    logic [TIME_W-1:0] edge_stamp, press_stamp, release_stamp;

    t_event            expected_events[$];
    t_event            expected_code;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count    = 0;
    int unsigned       hold_cycles    = 0;
    bit                in_gaps_on     = 1'b1;
    bit                out_stalls_on  = 1'b1;
    logic [TIME_W-1:0] clock_ms;

    function automatic void reset_model();
        db_ms         = DEBOUNCE_RST;
        dc_ms         = DCLICK_RST;
        lp_ms         = LONG_RST;
        pin_last      = 1'b1;
        level_settled = 1'b1;
        long_done     = 1'b0;
        window_open   = 1'b0;
        edge_stamp    = '0;
        press_stamp   = '0;
        release_stamp = '0;
    endfunction

    // All time differences wrap modulo 2^32
    function automatic t_event classify_sample(input logic lvl, input logic [TIME_W-1:0] t);
        if (lvl != pin_last) begin
            pin_last   = lvl;
            edge_stamp = t;
            return EV_NONE;
        end
        if ((t - edge_stamp) < {16'd0, db_ms})
            return EV_NONE;

        if (lvl != level_settled) begin
            level_settled = lvl;
            if (!lvl) begin
                if (window_open && (t - release_stamp) < {16'd0, dc_ms}) begin
                    // second press: no new press start, and its release opens no window
                    window_open = 1'b0;
                    long_done   = 1'b1;
                    return EV_DOUBLE;
                end
                press_stamp = t;
                long_done   = 1'b0;
                window_open = 1'b0;
            end else if (!long_done) begin
                release_stamp = t;
                window_open   = 1'b1;
            end
        end

        if (!level_settled && !long_done && (t - press_stamp) >= {16'd0, lp_ms}) begin
            long_done   = 1'b1;
            window_open = 1'b0;
            return EV_LONG;
        end
        if (window_open && (t - release_stamp) >= {16'd0, dc_ms}) begin
            window_open = 1'b0;
            return EV_SINGLE;
        end
        return EV_NONE;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_events.size() == 0) begin
                note_mismatch($sformatf("unexpected event code %0d", o_event_code));
            end else begin
                expected_code = expected_events.pop_front();
                if (o_event_code !== expected_code)
                    note_mismatch($sformatf("event code expected %0d, got %0d",
                                            expected_code, o_event_code));
            end
        end
    end

    // Result receiver: random stalls, or one long hold-off on request
    initial begin : result_side
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_cycles != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                stall = out_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Leaves valid high after the transfer so that a back-to-back sample needs no gap
    task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] t);
        int unsigned gap;
        gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_raw_level <= lvl;
        i_now_ms    <= t;
        do @(posedge i_clk); while (!o_in_ready);
        expected_events.push_back(classify_sample(lvl, t));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE: db_ms = value;
            CFG_DCLICK:   dc_ms = value;
            CFG_LONG:     lp_ms = value;
            default: ;
        endcase
    endtask

    // Only called with the block idle
    task automatic set_config(input logic [CFG_W-1:0] db, dc, lp);
        write_reg(CFG_DEBOUNCE, db);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_DCLICK, dc);
        write_reg(CFG_LONG, lp);
        i_cfg_valid <= 1'b0;
    endtask

    // Time steps biased onto the debounce, window and hold thresholds
    function automatic logic [TIME_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 3);
            1:       return db_ms;
            2:       return db_ms + 1;
            3:       return (db_ms == 0) ? 0 : db_ms - 1;
            4:       return dc_ms;
            5:       return (dc_ms > db_ms) ? dc_ms - db_ms : 0;
            6:       return lp_ms;
            default: return $urandom_range(0, 2 * lp_ms + 2);
        endcase
    endfunction

    // Runs of equal levels with the odd bounce, plus stray samples at arbitrary times
    task automatic run_gestures(input int unsigned count);
        logic        lvl;
        int unsigned run_len;
        int unsigned sent;
        lvl  = 1'b0;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                clock_ms = $urandom;
                send_sample(1'($urandom_range(0, 1)), clock_ms);
                sent++;
            end else begin
                run_len = $urandom_range(1, 5);
                if ($urandom_range(0, 4) == 0) begin
                    clock_ms += $urandom_range(0, 3);
                    send_sample(~lvl, clock_ms);
                    sent++;
                end
                repeat (run_len) begin
                    send_sample(lvl, clock_ms);
                    clock_ms += pick_step();
                    sent++;
                end
                lvl = ~lvl;
            end
        end
    endtask

    // Double, long and single press at reset settings, across the timestamp wrap
    task automatic test_click_patterns();
        logic [TIME_W-1:0] base;
        base = 32'hFFFF_FF00;
        send_sample(1'b0, base);
        send_sample(1'b0, base + 60);
        send_sample(1'b1, base + 100);
        send_sample(1'b1, base + 160);
        send_sample(1'b0, base + 200);
        send_sample(1'b0, base + 260);
        send_sample(1'b1, base + 300);
        send_sample(1'b1, base + 360);
        send_sample(1'b0, base + 700);
        send_sample(1'b0, base + 760);
        send_sample(1'b0, base + 1800);
        send_sample(1'b1, base + 1900);
        send_sample(1'b1, base + 1960);
        send_sample(1'b0, base + 2000);
        send_sample(1'b0, base + 2060);
        send_sample(1'b1, base + 2100);
        send_sample(1'b1, base + 2160);
        send_sample(1'b1, base + 2500);
        drain_results();
    endtask

    // Zero thresholds; timestamps at both ends of the range, time running backwards
    task automatic test_zero_settings();
        set_config('0, '0, '0);
        send_sample(1'b0, 32'h0000_0000);
        send_sample(1'b0, 32'h0000_0000);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'hFFFF_FFFF);
        drain_results();
        set_config('0, '0, 16'hFFFF);
        send_sample(1'b0, 32'd5);
        send_sample(1'b0, 32'd5);
        send_sample(1'b1, 32'd6);
        send_sample(1'b1, 32'd6);
        drain_results();
    endtask

    // Receiver holds off while samples keep coming, so the input side backs up
    task automatic test_backpressure();
        in_gaps_on = 1'b0;
        set_config(DEBOUNCE_RST, DCLICK_RST, LONG_RST);
        clock_ms    = $urandom;
        hold_cycles = 200;
        run_gestures(40);
        drain_results();
        in_gaps_on = 1'b1;
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       set_config(DEBOUNCE_RST, DCLICK_RST, LONG_RST);
                1:       set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2:       set_config('0, '0, '0);
                7:       set_config(16'($urandom), 16'($urandom), 16'($urandom));
                default: set_config(16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)),
                                    16'($urandom_range(0, 1500)));
            endcase
            in_gaps_on    = ($urandom_range(0, 3) != 0);
            out_stalls_on = ($urandom_range(0, 3) != 0);
            clock_ms      = $urandom;
            run_gestures(90);
            drain_results();
        end
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
    endtask

    initial begin
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_click_patterns();
        test_zero_settings();
        test_backpressure();
        test_random_settings();
        drain_results();
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_cfg.sv
hw/rtl/bcc_core.sv
hw/rtl/button_click_classifier.sv
verif/button_click_classifier_test.sv
